FILE: hw/rtl/cau_pkg.sv
package cau_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int SUM_W  = PROD_W + 1;
	localparam int REM_W  = 3 * DATA_WIDTH + FRAC_BITS + 1;
	localparam int MAG_W  = DATA_WIDTH + 1;
	localparam int NSTG   = DATA_WIDTH + 1;

	localparam int PTR_W      = 2;
	localparam int CNT_W      = PTR_W + 1;
	localparam int FIFO_DEPTH = 1 << PTR_W;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_INC = 3'd4;

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic signed [PROD_W-1:0]     prod_t;

	typedef struct packed {
		logic [2:0] cmd;
		word_t      ar;
		word_t      ai;
		word_t      br;
		word_t      bi;
		prod_t      p_rr;
		prod_t      p_ii;
		prod_t      p_ri;
		prod_t      p_ir;
		prod_t      p_bb;
		prod_t      p_cc;
	} front_ent_t;

	typedef struct packed {
		logic                  is_div;
		logic                  dz;
		logic                  ovf_r;
		logic                  ovf_i;
		logic                  neg_r;
		logic                  neg_i;
		logic [REM_W-1:0]      rem_r;
		logic [REM_W-1:0]      rem_i;
		logic [SUM_W-1:0]      den;
		logic [DATA_WIDTH-1:0] q_r;
		logic [DATA_WIDTH-1:0] q_i;
		logic [MAG_W-1:0]      m_r;
		logic [MAG_W-1:0]      m_i;
	} div_stage_t;

endpackage

FILE: hw/rtl/cau_in_if.sv
interface cau_in_if import cau_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] command;
	word_t      a_real;
	word_t      a_imag;
	word_t      b_real;
	word_t      b_imag;

	modport source (output valid, command, a_real, a_imag, b_real, b_imag, input ready);
	modport sink (input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

FILE: hw/rtl/cau_out_if.sv
interface cau_out_if import cau_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t res_real;
	word_t res_imag;
	logic  div_zero;
	logic  saturated;

	modport source (output valid, res_real, res_imag, div_zero, saturated, input ready);
	modport sink (input valid, res_real, res_imag, div_zero, saturated, output ready);
endinterface

FILE: hw/rtl/cau_front.sv
module cau_front import cau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cau_in_if.sink     operands,
	output front_ent_t ent,
	output logic       ent_valid,
	input  logic       ent_ready
);

	logic       vld_s1;
	front_ent_t ent_s1;
	logic       adv;

	assign adv = !vld_s1 || ent_ready;
	assign operands.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= operands.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && operands.valid) begin
			ent_s1.cmd  <= operands.command;
			ent_s1.ar   <= operands.a_real;
			ent_s1.ai   <= operands.a_imag;
			ent_s1.br   <= operands.b_real;
			ent_s1.bi   <= operands.b_imag;
			ent_s1.p_rr <= prod_t'(operands.a_real) * prod_t'(operands.b_real);
			ent_s1.p_ii <= prod_t'(operands.a_imag) * prod_t'(operands.b_imag);
			ent_s1.p_ri <= prod_t'(operands.a_real) * prod_t'(operands.b_imag);
			ent_s1.p_ir <= prod_t'(operands.a_imag) * prod_t'(operands.b_real);
			ent_s1.p_bb <= prod_t'(operands.b_real) * prod_t'(operands.b_real);
			ent_s1.p_cc <= prod_t'(operands.b_imag) * prod_t'(operands.b_imag);
		end
	end

	assign ent       = ent_s1;
	assign ent_valid = vld_s1;

endmodule

FILE: hw/rtl/cau_fifo.sv
module cau_fifo import cau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  front_ent_t wr_ent,
	input  logic       wr_valid,
	output logic       wr_ready,
	output front_ent_t rd_ent,
	output logic       rd_valid,
	input  logic       rd_ready
);

	front_ent_t       mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = cnt_q != CNT_W'(FIFO_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_ent   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_ent;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("queue count out of range");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count not decremented on pop");

endmodule

FILE: hw/rtl/cau_back.sv
module cau_back import cau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  front_ent_t head,
	input  logic       head_valid,
	output logic       head_ready,
	cau_out_if.source  result
);

	localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(1) << FRAC_BITS;
	localparam logic [MAG_W-1:0]        TOP_M = MAG_W'(1) << DATA_WIDTH;
	localparam logic [MAG_W-1:0]        LIM_M = MAG_W'(1) << (DATA_WIDTH - 1);

	logic       stg_vld_s [NSTG+1];
	div_stage_t stg_s     [NSTG+1];
	div_stage_t stg_nx    [NSTG+1];
	logic       en;

	logic                    res_vld_q;
	word_t                   res_real_q;
	word_t                   res_imag_q;
	logic                    res_dz_q;
	logic                    res_sat_q;

	logic signed [SUM_W-1:0] s_r;
	logic signed [SUM_W-1:0] s_i;
	logic        [SUM_W-1:0] a_r;
	logic        [SUM_W-1:0] a_i;
	logic        [SUM_W-1:0] den;
	logic                    dz;
	logic                    is_div;

	logic [MAG_W-1:0]        fm_r;
	logic [MAG_W-1:0]        fm_i;
	logic [DATA_WIDTH:0]     cl_r;
	logic [DATA_WIDTH:0]     cl_i;

	function automatic logic [MAG_W-1:0] sat_mag(input logic [SUM_W-1:0] m);
		if (|m[SUM_W-1:DATA_WIDTH]) begin
			return TOP_M;
		end
		return {1'b0, m[DATA_WIDTH-1:0]};
	endfunction

	// {saturated, value}
	function automatic logic [DATA_WIDTH:0] clip(input logic neg, input logic [MAG_W-1:0] m);
		logic [MAG_W-1:0] c;
		logic [MAG_W-1:0] n;
		if (neg) begin
			c = (m > LIM_M) ? LIM_M : m;
			n = MAG_W'(0) - c;
			return {m > LIM_M, n[DATA_WIDTH-1:0]};
		end
		c = (m > LIM_M - 1'b1) ? LIM_M - 1'b1 : m;
		return {m > LIM_M - 1'b1, c[DATA_WIDTH-1:0]};
	endfunction

	assign en         = !res_vld_q || result.ready;
	assign head_ready = en;

	always_comb begin
		s_r = '0;
		s_i = '0;
		case (head.cmd)
			CMD_ADD: begin
				s_r = SUM_W'(head.ar) + SUM_W'(head.br);
				s_i = SUM_W'(head.ai) + SUM_W'(head.bi);
			end
			CMD_SUB: begin
				s_r = SUM_W'(head.ar) - SUM_W'(head.br);
				s_i = SUM_W'(head.ai) - SUM_W'(head.bi);
			end
			CMD_MUL: begin
				s_r = SUM_W'(head.p_rr) - SUM_W'(head.p_ii);
				s_i = SUM_W'(head.p_ri) + SUM_W'(head.p_ir);
			end
			CMD_DIV: begin
				s_r = SUM_W'(head.p_rr) + SUM_W'(head.p_ii);
				s_i = SUM_W'(head.p_ir) - SUM_W'(head.p_ri);
			end
			CMD_INC: begin
				s_r = SUM_W'(head.ar) + ONE_Q;
				s_i = SUM_W'(head.ai);
			end
			default: begin
				s_r = '0;
				s_i = '0;
			end
		endcase
	end

	always_comb begin
		den    = SUM_W'($unsigned(head.p_bb)) + SUM_W'($unsigned(head.p_cc));
		dz     = (head.cmd == CMD_DIV) && (den == '0);
		is_div = (head.cmd == CMD_DIV) && !dz;
		a_r    = s_r[SUM_W-1] ? SUM_W'(-s_r) : SUM_W'(s_r);
		a_i    = s_i[SUM_W-1] ? SUM_W'(-s_i) : SUM_W'(s_i);

		stg_nx[0].is_div = is_div;
		stg_nx[0].dz     = dz;
		stg_nx[0].ovf_r  = 1'b0;
		stg_nx[0].ovf_i  = 1'b0;
		stg_nx[0].neg_r  = s_r[SUM_W-1] && !dz;
		stg_nx[0].neg_i  = s_i[SUM_W-1] && !dz;
		stg_nx[0].rem_r  = REM_W'(a_r) << FRAC_BITS;
		stg_nx[0].rem_i  = REM_W'(a_i) << FRAC_BITS;
		stg_nx[0].den    = den;
		stg_nx[0].q_r    = '0;
		stg_nx[0].q_i    = '0;
		if (dz) begin
			stg_nx[0].m_r = '0;
			stg_nx[0].m_i = '0;
		end else if (head.cmd == CMD_MUL) begin
			stg_nx[0].m_r = sat_mag(a_r >> FRAC_BITS);
			stg_nx[0].m_i = sat_mag(a_i >> FRAC_BITS);
		end else begin
			stg_nx[0].m_r = sat_mag(a_r);
			stg_nx[0].m_i = sat_mag(a_i);
		end
	end

	for (genvar j = 1; j <= NSTG; j++) begin : g_div
		if (j == 1) begin : g_ovf
			always_comb begin
				stg_nx[j]       = stg_s[j-1];
				stg_nx[j].ovf_r = stg_s[j-1].rem_r >= (REM_W'(stg_s[j-1].den) << DATA_WIDTH);
				stg_nx[j].ovf_i = stg_s[j-1].rem_i >= (REM_W'(stg_s[j-1].den) << DATA_WIDTH);
			end
		end else begin : g_bit
			localparam int SH = NSTG - j;
			logic [REM_W-1:0] d;
			always_comb begin
				d         = REM_W'(stg_s[j-1].den) << SH;
				stg_nx[j] = stg_s[j-1];
				if (stg_s[j-1].rem_r >= d) begin
					stg_nx[j].rem_r = stg_s[j-1].rem_r - d;
					stg_nx[j].q_r   = {stg_s[j-1].q_r[DATA_WIDTH-2:0], 1'b1};
				end else begin
					stg_nx[j].q_r   = {stg_s[j-1].q_r[DATA_WIDTH-2:0], 1'b0};
				end
				if (stg_s[j-1].rem_i >= d) begin
					stg_nx[j].rem_i = stg_s[j-1].rem_i - d;
					stg_nx[j].q_i   = {stg_s[j-1].q_i[DATA_WIDTH-2:0], 1'b1};
				end else begin
					stg_nx[j].q_i   = {stg_s[j-1].q_i[DATA_WIDTH-2:0], 1'b0};
				end
			end
		end
	end

	for (genvar j = 0; j <= NSTG; j++) begin : g_stg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_vld_s[j] <= 1'b0;
			end else if (en) begin
				stg_vld_s[j] <= (j == 0) ? head_valid : stg_vld_s[(j == 0) ? 0 : j-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[j] <= stg_nx[j];
			end
		end
	end

	always_comb begin
		if (stg_s[NSTG].is_div) begin
			fm_r = stg_s[NSTG].ovf_r ? TOP_M : {1'b0, stg_s[NSTG].q_r};
			fm_i = stg_s[NSTG].ovf_i ? TOP_M : {1'b0, stg_s[NSTG].q_i};
		end else begin
			fm_r = stg_s[NSTG].m_r;
			fm_i = stg_s[NSTG].m_i;
		end
		cl_r = clip(stg_s[NSTG].neg_r, fm_r);
		cl_i = clip(stg_s[NSTG].neg_i, fm_i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= stg_vld_s[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_real_q <= cl_r[DATA_WIDTH-1:0];
			res_imag_q <= cl_i[DATA_WIDTH-1:0];
			res_dz_q   <= stg_s[NSTG].dz;
			res_sat_q  <= cl_r[DATA_WIDTH] || cl_i[DATA_WIDTH];
		end
	end

	assign result.valid     = res_vld_q;
	assign result.res_real  = res_real_q;
	assign result.res_imag  = res_imag_q;
	assign result.div_zero  = res_dz_q;
	assign result.saturated = res_sat_q;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.div_zero |->
			result.res_real == '0 && result.res_imag == '0 && !result.saturated)
		else $error("divide by zero result not cleared");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> stg_vld_s[NSTG] == $past(stg_vld_s[NSTG]))
		else $error("pipeline advanced while output stalled");

endmodule

FILE: hw/rtl/complex_arithmetic_unit.sv
// Complex add, subtract, multiply, divide and real-part increment on signed
// Q8.8 operands, one transfer per cycle in and out when the output is not
// stalled. Items pass a product stage, a four-entry queue and a back end
// built on the restoring divider, which runs as DATA_WIDTH + 1 pipelined
// stages (overflow check, then compare-subtract) shared by all commands.
// Products and quotients truncate toward zero and all results saturate;
// a zero divisor gives zero with div_zero set. Unknown commands give zero.
module complex_arithmetic_unit import cau_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	cau_in_if.sink    operands,
	cau_out_if.source result
);

	front_ent_t f_ent;
	logic       f_valid;
	logic       f_ready;
	front_ent_t q_ent;
	logic       q_valid;
	logic       q_ready;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.operands  (operands),
		.ent       (f_ent),
		.ent_valid (f_valid),
		.ent_ready (f_ready)
	);

	cau_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_ent   (f_ent),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_ent   (q_ent),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	cau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_ent),
		.head_valid (q_valid),
		.head_ready (q_ready),
		.result     (result)
	);

endmodule
